[rtl/core/hrpbf_pkg.sv]
// ----------------------------------------------------------------------------
// hrpbf_pkg
// Shared types and constants for the heart-rate packet parser and biquad.
// ----------------------------------------------------------------------------
package hrpbf_pkg;

	localparam int RATE_W     = 8;
	localparam int COEF_W     = 16;
	localparam int Y_W        = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [RATE_W-1:0] HDR_BYTE = 8'h16;

	localparam logic signed [Y_W-1:0] Y_MAX = 24'sh7FFFFF;
	localparam logic signed [Y_W-1:0] Y_MIN = -24'sh800000;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B0  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B2  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A1  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A2  = 3'd6;

	localparam logic [RATE_W-1:0]        RST_MIN_RATE = 8'd50;
	localparam logic [RATE_W-1:0]        RST_MAX_RATE = 8'd220;
	localparam logic signed [COEF_W-1:0] RST_COEF_B0  = 16'sd1105;
	localparam logic signed [COEF_W-1:0] RST_COEF_B1  = 16'sd2210;
	localparam logic signed [COEF_W-1:0] RST_COEF_B2  = 16'sd1105;
	localparam logic signed [COEF_W-1:0] RST_COEF_A1  = -16'sd18725;
	localparam logic signed [COEF_W-1:0] RST_COEF_A2  = 16'sd6762;

	typedef enum logic [1:0] {
		STAT_FILTERED = 2'd0,
		STAT_HELD     = 2'd1,
		STAT_PRIMED   = 2'd2
	} status_t;

	typedef struct packed {
		logic [RATE_W-1:0]        min_rate;
		logic [RATE_W-1:0]        max_rate;
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} cfg_t;

	typedef struct packed {
		logic [RATE_W-1:0] parsed;
		status_t           status;
		logic [RATE_W-1:0] shown;
	} res_t;

endpackage

[rtl/core/hrpbf_parser.sv]
// ----------------------------------------------------------------------------
// hrpbf_parser
// Header search and packet framing; flags the byte that completes a packet.
// ----------------------------------------------------------------------------
module hrpbf_parser #(
	parameter int PACKET_BYTES = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [hrpbf_pkg::RATE_W-1:0]   in_byte,
	output logic                           done,
	output logic [hrpbf_pkg::RATE_W-1:0]   raw
);

	localparam int CNT_W = $clog2(PACKET_BYTES + 1);

	logic                          busy_q;
	logic [CNT_W-1:0]              count_q;
	logic [hrpbf_pkg::RATE_W-1:0]  rate_byte_q;
	logic [CNT_W-1:0]              count_next;
	logic                          first_data;

	assign first_data = (count_q == CNT_W'(1));
	assign count_next = count_q + CNT_W'(1);
	assign done       = busy_q && (count_next >= CNT_W'(PACKET_BYTES));
	assign raw        = first_data ? in_byte : rate_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			if (!busy_q) begin
				if (in_byte == hrpbf_pkg::HDR_BYTE) begin
					busy_q  <= 1'b1;
					count_q <= CNT_W'(1);
				end
			end else if (done) begin
				busy_q  <= 1'b0;
				count_q <= '0;
			end else begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && busy_q && first_data) begin
			rate_byte_q <= in_byte;
		end
	end

endmodule

[rtl/core/hrpbf_biquad.sv]
// ----------------------------------------------------------------------------
// hrpbf_biquad
// Range check, priming and direct-form-I low-pass biquad with its histories.
// ----------------------------------------------------------------------------
module hrpbf_biquad #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [hrpbf_pkg::RATE_W-1:0]  raw,
	input  hrpbf_pkg::cfg_t               cfg,
	output hrpbf_pkg::res_t               res
);

	localparam int RW    = hrpbf_pkg::RATE_W;
	localparam int CW    = hrpbf_pkg::COEF_W;
	localparam int YW    = hrpbf_pkg::Y_W;
	localparam int PX_W  = CW + RW + 1;
	localparam int FF_W  = PX_W + 2;
	localparam int PY_W  = CW + YW;
	localparam int FB_W  = PY_W + 1;
	localparam int ACC_W = FB_W + 1;
	localparam int PR_W  = YW + 1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(hrpbf_pkg::Y_MAX);
	localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(hrpbf_pkg::Y_MIN);

	logic [RW-1:0]        x1_q, x2_q, held_q, pub_q;
	logic signed [YW-1:0] y1_q, y2_q;
	logic                 primed_q;

	logic signed [RW:0]    xs0, xs1, xs2;
	logic signed [PX_W-1:0] p0, p1, p2;
	logic signed [PY_W-1:0] q1, q2;
	logic signed [FF_W-1:0] ff;
	logic signed [FB_W-1:0] fb, fb_sh;
	logic signed [ACC_W-1:0] acc;
	logic signed [YW-1:0]  y_new;
	logic [YW-2:0]         whole_w;
	logic [RW-1:0]         whole;
	logic [PR_W-1:0]       prime_w;
	logic signed [YW-1:0]  y_prime;
	logic                  out_of_range;

	assign xs0 = {1'b0, raw};
	assign xs1 = {1'b0, x1_q};
	assign xs2 = {1'b0, x2_q};

	assign p0 = cfg.b0 * xs0;
	assign p1 = cfg.b1 * xs1;
	assign p2 = cfg.b2 * xs2;
	assign q1 = cfg.a1 * y1_q;
	assign q2 = cfg.a2 * y2_q;

	assign ff    = FF_W'(p0) + FF_W'(p1) + FF_W'(p2);
	assign fb    = FB_W'(q1) + FB_W'(q2);
	assign fb_sh = fb >>> COEF_FRAC_BITS;
	assign acc   = ACC_W'(ff) - ACC_W'(fb_sh);

	always_comb begin
		if (acc > ACC_MAX) begin
			y_new = hrpbf_pkg::Y_MAX;
		end else if (acc < ACC_MIN) begin
			y_new = hrpbf_pkg::Y_MIN;
		end else begin
			y_new = acc[YW-1:0];
		end
	end

	assign whole_w = y_new[YW-2:0] >> COEF_FRAC_BITS;

	always_comb begin
		if (y_new[YW-1]) begin
			whole = '0;
		end else if (whole_w > (YW-1)'(255)) begin
			whole = '1;
		end else begin
			whole = whole_w[RW-1:0];
		end
	end

	assign prime_w = PR_W'(raw) << COEF_FRAC_BITS;

	always_comb begin
		if (prime_w > PR_W'(hrpbf_pkg::Y_MAX)) begin
			y_prime = hrpbf_pkg::Y_MAX;
		end else begin
			y_prime = prime_w[YW-1:0];
		end
	end

	assign out_of_range = (raw < cfg.min_rate) || (raw > cfg.max_rate);

	always_comb begin
		if (out_of_range) begin
			res.parsed = held_q;
			res.status = hrpbf_pkg::STAT_HELD;
			res.shown  = pub_q;
		end else if (!primed_q) begin
			res.parsed = raw;
			res.status = hrpbf_pkg::STAT_PRIMED;
			res.shown  = pub_q;
		end else begin
			res.parsed = whole;
			res.status = hrpbf_pkg::STAT_FILTERED;
			res.shown  = whole;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q     <= '0;
			x2_q     <= '0;
			y1_q     <= '0;
			y2_q     <= '0;
			primed_q <= 1'b0;
			held_q   <= '0;
			pub_q    <= '0;
		end else if (advance && !out_of_range) begin
			if (!primed_q) begin
				x1_q     <= raw;
				x2_q     <= raw;
				y1_q     <= y_prime;
				y2_q     <= y_prime;
				held_q   <= raw;
				primed_q <= 1'b1;
			end else begin
				x2_q   <= x1_q;
				x1_q   <= raw;
				y2_q   <= y1_q;
				y1_q   <= y_new;
				held_q <= whole;
				pub_q  <= whole;
			end
		end
	end

endmodule

[rtl/core/heart_rate_packet_biquad_filter.sv]
// ----------------------------------------------------------------------------
// heart_rate_packet_biquad_filter
// Heart-rate packet parser with a second-order low-pass smoothing filter.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_stall is low; the filter is one
//   pass of five multiplies between the packet register and result register.
// Flow: a completed packet waits in the packet register while a previous
//   result is stalled (in_stall is then high), then its result is registered.
// Reset: clears framing, filter histories and output valid, and loads the
//   default limits and coefficients; there is no clearing pass.
module heart_rate_packet_biquad_filter #(
	parameter int PACKET_BYTES   = 4,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr,
	input  logic [hrpbf_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [hrpbf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [hrpbf_pkg::RATE_W-1:0]       in_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [hrpbf_pkg::RATE_W-1:0]       parsed_rate,
	output logic [1:0]                         packet_status,
	output logic [hrpbf_pkg::RATE_W-1:0]       shown_rate
);

	hrpbf_pkg::cfg_t cfg_q;

	logic                          in_accept;
	logic                          pkt_done;
	logic [hrpbf_pkg::RATE_W-1:0]  pkt_raw;
	logic                          pkt_valid_s1;
	logic [hrpbf_pkg::RATE_W-1:0]  pkt_raw_s1;
	logic                          s1_adv;
	logic                          out_valid_q;
	hrpbf_pkg::res_t               res;
	hrpbf_pkg::res_t               res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_rate <= hrpbf_pkg::RST_MIN_RATE;
			cfg_q.max_rate <= hrpbf_pkg::RST_MAX_RATE;
			cfg_q.b0       <= hrpbf_pkg::RST_COEF_B0;
			cfg_q.b1       <= hrpbf_pkg::RST_COEF_B1;
			cfg_q.b2       <= hrpbf_pkg::RST_COEF_B2;
			cfg_q.a1       <= hrpbf_pkg::RST_COEF_A1;
			cfg_q.a2       <= hrpbf_pkg::RST_COEF_A2;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				hrpbf_pkg::REG_MIN_RATE: cfg_q.min_rate <= cfg_data[hrpbf_pkg::RATE_W-1:0];
				hrpbf_pkg::REG_MAX_RATE: cfg_q.max_rate <= cfg_data[hrpbf_pkg::RATE_W-1:0];
				hrpbf_pkg::REG_COEF_B0:  cfg_q.b0       <= cfg_data;
				hrpbf_pkg::REG_COEF_B1:  cfg_q.b1       <= cfg_data;
				hrpbf_pkg::REG_COEF_B2:  cfg_q.b2       <= cfg_data;
				hrpbf_pkg::REG_COEF_A1:  cfg_q.a1       <= cfg_data;
				hrpbf_pkg::REG_COEF_A2:  cfg_q.a2       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s1_adv    = pkt_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = pkt_valid_s1 && !s1_adv;
	assign in_accept = in_valid && !in_stall;

	hrpbf_parser #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_accept),
		.in_byte (in_byte),
		.done    (pkt_done),
		.raw     (pkt_raw)
	);

	// hold the completed packet until the result register frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_s1 <= 1'b0;
		end else if (in_accept) begin
			pkt_valid_s1 <= pkt_done;
		end else if (s1_adv) begin
			pkt_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && pkt_done) begin
			pkt_raw_s1 <= pkt_raw;
		end
	end

	hrpbf_biquad #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_biquad (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (s1_adv),
		.raw     (pkt_raw_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign parsed_rate   = res_q.parsed;
	assign packet_status = res_q.status;
	assign shown_rate    = res_q.shown;

	a_filtered_publishes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (packet_status == hrpbf_pkg::STAT_FILTERED) |->
		shown_rate == parsed_rate)
		else $error("filtered request does not publish its rate");

	a_packet_staged: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && pkt_done |=> pkt_valid_s1 && (pkt_raw_s1 == $past(pkt_raw)))
		else $error("completed packet not staged");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid_s1 && !s1_adv |=> pkt_valid_s1 && $stable(pkt_raw_s1))
		else $error("staged packet lost while output stalled");

endmodule

[bench/tb_heart_rate_packet_biquad_filter.sv]
// ----------------------------------------------------------------------------
// tb_heart_rate_packet_biquad_filter
// Self-checking bench for the heart-rate packet parser and biquad smoother.
// A byte-level model of the framing, range check, priming and fixed-point
// filter predicts one result per completed packet. Directed packets cover the
// range edges, priming, held values and coefficient saturation; random phases
// then mix well-formed packets, noise and truncated packets under changing
// settings, with random gaps on the byte side and random stalls on the result
// side.
// ----------------------------------------------------------------------------
module tb_heart_rate_packet_biquad_filter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PACKET_BYTES   = 4;
	localparam int COEF_FRAC_BITS = 14;
	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int MAX_WAIT       = 4;
	localparam int DRAIN_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_BYTES    = 130;
	localparam int PAUSE_PHASE    = 5;
	localparam longint RATE_CEIL  = 255;

	localparam logic [hrpbf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             cfg_wr    = 1'b0;
	logic [hrpbf_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [hrpbf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                             in_valid  = 1'b0;
	logic                             in_stall;
	logic [hrpbf_pkg::RATE_W-1:0]     in_byte   = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [hrpbf_pkg::RATE_W-1:0]     parsed_rate;
	logic [1:0]                       packet_status;
	logic [hrpbf_pkg::RATE_W-1:0]     shown_rate;

	hrpbf_pkg::cfg_t                  cfg_shadow;
	logic                             framing;
	int unsigned                      byte_pos;
	logic [hrpbf_pkg::RATE_W-1:0]     captured_rate;
	logic [hrpbf_pkg::RATE_W-1:0]     x_hist1, x_hist2;
	logic signed [hrpbf_pkg::Y_W-1:0] y_hist1, y_hist2;
	logic                             filter_primed;
	logic [hrpbf_pkg::RATE_W-1:0]     held_rate;
	logic [hrpbf_pkg::RATE_W-1:0]     published;
	hrpbf_pkg::res_t                  rate_queue[$];

	int error_count  = 0;
	int idle_cycles  = 0;
	int framed_bytes = 0;
	bit calm         = 1'b0;

	heart_rate_packet_biquad_filter #(
		.PACKET_BYTES   (PACKET_BYTES),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_wr),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.parsed_rate   (parsed_rate),
		.packet_status (packet_status),
		.shown_rate    (shown_rate)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	task automatic report(input string msg);
		$display("%0t ERROR: %s", $time, msg);
		error_count++;
	endtask

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic logic signed [hrpbf_pkg::Y_W-1:0] clip_y(input longint v);
		if (v > longint'(hrpbf_pkg::Y_MAX))
			return hrpbf_pkg::Y_MAX;
		if (v < longint'(hrpbf_pkg::Y_MIN))
			return hrpbf_pkg::Y_MIN;
		return v[hrpbf_pkg::Y_W-1:0];
	endfunction

	task automatic track_byte(input logic [hrpbf_pkg::RATE_W-1:0] b);
		hrpbf_pkg::res_t                  r;
		longint                           ff, fb, whole;
		logic signed [hrpbf_pkg::Y_W-1:0] acc_y;
		if (!framing) begin
			if (b == hrpbf_pkg::HDR_BYTE) begin
				framing  = 1'b1;
				byte_pos = 1;
			end
			return;
		end
		if (byte_pos == 1)
			captured_rate = b;
		byte_pos = (byte_pos + 1) & 7;
		if (byte_pos < PACKET_BYTES)
			return;
		framing  = 1'b0;
		byte_pos = 0;
		if (captured_rate < cfg_shadow.min_rate || captured_rate > cfg_shadow.max_rate) begin
			r.parsed = held_rate;
			r.status = hrpbf_pkg::STAT_HELD;
		end else if (!filter_primed) begin
			x_hist1       = captured_rate;
			x_hist2       = captured_rate;
			y_hist1       = clip_y(longint'(captured_rate) <<< COEF_FRAC_BITS);
			y_hist2       = y_hist1;
			held_rate     = captured_rate;
			filter_primed = 1'b1;
			r.parsed      = captured_rate;
			r.status      = hrpbf_pkg::STAT_PRIMED;
		end else begin
			ff = longint'($signed(cfg_shadow.b0)) * longint'(captured_rate)
			   + longint'($signed(cfg_shadow.b1)) * longint'(x_hist1)
			   + longint'($signed(cfg_shadow.b2)) * longint'(x_hist2);
			fb = longint'($signed(cfg_shadow.a1)) * longint'(y_hist1)
			   + longint'($signed(cfg_shadow.a2)) * longint'(y_hist2);
			acc_y   = clip_y(ff - (fb >>> COEF_FRAC_BITS));
			x_hist2 = x_hist1;
			x_hist1 = captured_rate;
			y_hist2 = y_hist1;
			y_hist1 = acc_y;
			if (acc_y < 0)
				whole = 0;
			else
				whole = longint'(acc_y) >>> COEF_FRAC_BITS;
			if (whole > RATE_CEIL)
				whole = RATE_CEIL;
			r.parsed  = whole[hrpbf_pkg::RATE_W-1:0];
			r.status  = hrpbf_pkg::STAT_FILTERED;
			held_rate = r.parsed;
			published = r.parsed;
		end
		r.shown = published;
		rate_queue.push_back(r);
	endtask

	task automatic send_byte(input logic [hrpbf_pkg::RATE_W-1:0] b);
		int gap;
		gap = draw_wait();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		if (framing || b == hrpbf_pkg::HDR_BYTE)
			framed_bytes++;
		track_byte(b);
	endtask

	task automatic send_packet(input logic [hrpbf_pkg::RATE_W-1:0] rate, fill1, fill2);
		send_byte(hrpbf_pkg::HDR_BYTE);
		send_byte(rate);
		send_byte(fill1);
		send_byte(fill2);
	endtask

	// drop the request, then let the last packet clear the filter pipeline
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (rate_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [hrpbf_pkg::CFG_IDX_W-1:0] idx,
			input logic [hrpbf_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr <= 1'b0;
		case (idx)
			hrpbf_pkg::REG_MIN_RATE: cfg_shadow.min_rate = data[hrpbf_pkg::RATE_W-1:0];
			hrpbf_pkg::REG_MAX_RATE: cfg_shadow.max_rate = data[hrpbf_pkg::RATE_W-1:0];
			hrpbf_pkg::REG_COEF_B0:  cfg_shadow.b0 = data;
			hrpbf_pkg::REG_COEF_B1:  cfg_shadow.b1 = data;
			hrpbf_pkg::REG_COEF_B2:  cfg_shadow.b2 = data;
			hrpbf_pkg::REG_COEF_A1:  cfg_shadow.a1 = data;
			hrpbf_pkg::REG_COEF_A2:  cfg_shadow.a2 = data;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [hrpbf_pkg::CFG_DATA_W-1:0] lo, hi, b0, b1, b2,
			a1, a2);
		write_reg(hrpbf_pkg::REG_MIN_RATE, lo);
		write_reg(hrpbf_pkg::REG_MAX_RATE, hi);
		write_reg(hrpbf_pkg::REG_COEF_B0, b0);
		write_reg(hrpbf_pkg::REG_COEF_B1, b1);
		write_reg(hrpbf_pkg::REG_COEF_B2, b2);
		write_reg(hrpbf_pkg::REG_COEF_A1, a1);
		write_reg(hrpbf_pkg::REG_COEF_A2, a2);
	endtask

	function automatic logic [hrpbf_pkg::COEF_W-1:0] rand_coef(
			input logic [hrpbf_pkg::COEF_W-1:0] base);
		if ($urandom_range(0, 1) != 0)
			return hrpbf_pkg::COEF_W'($urandom);
		return base + hrpbf_pkg::COEF_W'($urandom_range(0, 4095)) - 16'd2048;
	endfunction

	function automatic logic [hrpbf_pkg::RATE_W-1:0] pick_rate();
		int pick;
		pick = $urandom_range(0, 99);
		if (cfg_shadow.min_rate > cfg_shadow.max_rate || pick >= 85)
			return hrpbf_pkg::RATE_W'($urandom);
		if (pick < 60)
			return hrpbf_pkg::RATE_W'($urandom_range(cfg_shadow.min_rate,
					cfg_shadow.max_rate));
		if (pick < 68)
			return cfg_shadow.min_rate;
		if (pick < 76)
			return cfg_shadow.max_rate;
		if (pick < 80)
			return cfg_shadow.min_rate - 8'd1;
		return cfg_shadow.max_rate + 8'd1;
	endfunction

	task automatic test_framing_and_priming();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h15);
		// held value is still zero before the first accepted rate
		send_packet(8'd10, 8'hAA, 8'h55);
		send_packet(8'd50, hrpbf_pkg::HDR_BYTE, hrpbf_pkg::HDR_BYTE);
		send_packet(8'd221, 8'h00, 8'hFF);
		send_packet(8'd220, hrpbf_pkg::HDR_BYTE, 8'h00);
	endtask

	task automatic test_register_extremes();
		settle();
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(hrpbf_pkg::REG_MIN_RATE, 16'hA5C8);
		write_reg(hrpbf_pkg::REG_MAX_RATE, 16'h5A64);
		send_packet(8'd150, 8'h00, 8'hFF);
		settle();
		configure(16'h12FF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_packet(8'd255, 8'h5A, 8'hA5);
		settle();
		configure(16'h0000, 16'h00FF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_packet(8'd255, 8'hFF, 8'h00);
	endtask

	task automatic test_random_traffic();
		int phase, phase_start, pick, tail;
		bit paused;
		logic [hrpbf_pkg::RATE_W-1:0] b;
		paused = 1'b0;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			case (phase)
				0: configure(hrpbf_pkg::RST_MIN_RATE, hrpbf_pkg::RST_MAX_RATE,
						hrpbf_pkg::RST_COEF_B0, hrpbf_pkg::RST_COEF_B1,
						hrpbf_pkg::RST_COEF_B2, hrpbf_pkg::RST_COEF_A1,
						hrpbf_pkg::RST_COEF_A2);
				1: configure(16'h0000, 16'h00FF, hrpbf_pkg::RST_COEF_B0,
						hrpbf_pkg::RST_COEF_B1, hrpbf_pkg::RST_COEF_B2,
						hrpbf_pkg::RST_COEF_A1, hrpbf_pkg::RST_COEF_A2);
				2: configure(16'h0000, 16'h00FF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
						16'h8000, 16'h8000);
				3: configure(16'h0000, 16'h00FF, 16'h8000, 16'h8000, 16'h8000,
						16'h7FFF, 16'h7FFF);
				4: configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), 16'($urandom));
				default: configure({8'($urandom), 8'($urandom_range(0, 120))},
						{8'($urandom), 8'($urandom_range(120, 255))},
						rand_coef(hrpbf_pkg::RST_COEF_B0), rand_coef(hrpbf_pkg::RST_COEF_B1),
						rand_coef(hrpbf_pkg::RST_COEF_B2), rand_coef(hrpbf_pkg::RST_COEF_A1),
						rand_coef(hrpbf_pkg::RST_COEF_A2));
			endcase
			calm = ($urandom_range(0, 3) == 0);
			phase_start = framed_bytes;
			while (framed_bytes - phase_start < PHASE_BYTES) begin
				if ($urandom_range(0, 19) == 0)
					calm = ~calm;
				// hold the requests until every pending result is out
				if (phase == PAUSE_PHASE && !paused
						&& framed_bytes - phase_start >= PHASE_BYTES / 2) begin
					settle();
					paused = 1'b1;
				end
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					send_packet(pick_rate(), 8'($urandom), 8'($urandom));
				end else if (pick < 90) begin
					b = 8'($urandom);
					if (b == hrpbf_pkg::HDR_BYTE)
						b = ~b;
					send_byte(b);
				end else begin
					send_byte(hrpbf_pkg::HDR_BYTE);
					tail = $urandom_range(0, PACKET_BYTES - 2);
					repeat (tail) send_byte(8'($urandom));
				end
			end
		end
		calm = 1'b0;
	endtask

	always begin : result_sink
		hrpbf_pkg::res_t want;
		int              hold;
		@(posedge clk);
		if (arst_n && out_valid && !out_stall) begin
			if (rate_queue.size() == 0) begin
				report("result with no packet pending");
			end else begin
				want = rate_queue.pop_front();
				if (parsed_rate !== want.parsed)
					report($sformatf("parsed_rate %0d, expected %0d",
							parsed_rate, want.parsed));
				if (packet_status !== want.status)
					report($sformatf("packet_status %0d, expected %0d",
							packet_status, want.status));
				if (shown_rate !== want.shown)
					report($sformatf("shown_rate %0d, expected %0d",
							shown_rate, want.shown));
			end
			hold = draw_wait();
			if (hold > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		cfg_shadow = '{hrpbf_pkg::RST_MIN_RATE, hrpbf_pkg::RST_MAX_RATE,
				hrpbf_pkg::RST_COEF_B0, hrpbf_pkg::RST_COEF_B1, hrpbf_pkg::RST_COEF_B2,
				hrpbf_pkg::RST_COEF_A1, hrpbf_pkg::RST_COEF_A2};
		framing       = 1'b0;
		byte_pos      = 0;
		captured_rate = '0;
		x_hist1       = '0;
		x_hist2       = '0;
		y_hist1       = '0;
		y_hist2       = '0;
		filter_primed = 1'b0;
		held_rate     = '0;
		published     = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_framing_and_priming();
		test_register_extremes();
		test_random_traffic();
		settle();

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
